[sv/msa_pkg.sv]
// Shared constants and types for the multi-stack shared-array block.
// No dependencies; imported by msa_ram's users and the top level.
package msa_pkg;

  // Storage geometry
  localparam int TOTAL_ENTRIES = 96;
  localparam int NUM_STACKS    = 3;
  localparam int DATA_WIDTH    = 32;

  // Equal partition per stack; leftover entries at the top stay unused
  localparam int PART   = TOTAL_ENTRIES / NUM_STACKS;
  localparam int ADDR_W = $clog2(TOTAL_ENTRIES);
  localparam int FILL_W = $clog2(PART + 1);
  localparam int STK_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  // Port field widths
  localparam int OUT_W  = 32;
  localparam int CNT_W  = 6;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_DUMP  = 2'd2,
    OP_QUERY = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_DUMP = 3'b100
  } state_e;

endpackage

[sv/msa_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; read data holds until the next read enable.
module msa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/multi_stack_shared_array.sv]
// Timing: push, query, invalid and empty-stack words appear in the cycle after accept; a pop
// word passes the RAM read register and then the output register, as does the first word of a
// read-out, which then gives one word per cycle while the output is not stalled. One item is in
// flight at a time, set by the single read port of the entry RAM and its registered read.
// Reset: all fill counts clear (every stack empty); the entry RAM is not cleared and
// needs no clearing pass, since only entries below a fill count are ever read.
module multi_stack_shared_array
  import msa_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              opcode_i,
  input  logic [1:0]              stack_select_i,
  input  logic signed [31:0]      push_value_i,
  // Output channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] data_out_o,
  output logic [1:0]              status_o,
  output logic                    last_of_run_o,
  output logic                    is_full_o,
  output logic                    is_empty_o,
  output logic [CNT_W-1:0]        fill_count_o
);

  state_e state_q, state_d;

  // Per-stack fill counts
  logic [FILL_W-1:0] fill_q [NUM_STACKS];
  logic              fill_we;
  logic [FILL_W-1:0] fill_new;

  // Run registers for pop and read-out
  logic [ADDR_W-1:0] run_base_q, run_base_d;
  logic [FILL_W-1:0] run_fill_q, run_fill_d;
  logic [FILL_W-1:0] run_idx_q, run_idx_d;

  // Output register
  logic                    out_valid_q, out_valid_d;
  logic signed [OUT_W-1:0] out_data_q, out_data_d;
  status_e                 out_status_q, out_status_d;
  logic                    out_last_q, out_last_d;
  logic [FILL_W-1:0]       out_fill_q, out_fill_d;
  logic                    out_flags_q, out_flags_d;
  logic                    load_out;

  // RAM ports
  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  logic                  out_free, in_acc, sel_ok, run_last;
  logic [STK_W-1:0]      sel_idx;
  logic [FILL_W-1:0]     cur_fill;
  logic [ADDR_W-1:0]     cur_base;
  logic signed [OUT_W-1:0] rd_word;

  msa_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(TOTAL_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Decode the selected stack
  assign sel_ok   = int'(stack_select_i) < NUM_STACKS;
  assign sel_idx  = STK_W'(stack_select_i);
  assign cur_fill = fill_q[sel_idx];
  assign cur_base = ADDR_W'(int'(sel_idx) * PART);
  assign ram_wdata = DATA_WIDTH'($unsigned(push_value_i));
  assign ram_waddr = cur_base + ADDR_W'(cur_fill);

  // Sign-extend or trim the stored word to the output width
  assign rd_word  = OUT_W'($signed(ram_rdata));
  assign run_last = (run_idx_q + FILL_W'(1)) == run_fill_q;

  // Sequence one item: decode, access memory, load the output register
  always_comb begin
    state_d      = state_q;
    run_base_d   = run_base_q;
    run_fill_d   = run_fill_q;
    run_idx_d    = run_idx_q;
    fill_we      = 1'b0;
    fill_new     = cur_fill;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = cur_base;
    load_out     = 1'b0;
    out_data_d   = '0;
    out_status_d = ST_OK;
    out_last_d   = 1'b1;
    out_fill_d   = cur_fill;
    out_flags_d  = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!sel_ok) begin
            load_out     = 1'b1;
            out_status_d = ST_INVALID;
            out_fill_d   = '0;
            out_flags_d  = 1'b0;
          end else begin
            case (opcode_e'(opcode_i))
              OP_PUSH: begin
                load_out = 1'b1;
                if (cur_fill >= FILL_W'(PART)) begin
                  out_status_d = ST_FULL;
                end else begin
                  ram_we     = 1'b1;
                  fill_we    = 1'b1;
                  fill_new   = cur_fill + FILL_W'(1);
                  out_fill_d = fill_new;
                end
              end
              OP_POP: begin
                if (cur_fill == '0) begin
                  load_out     = 1'b1;
                  out_status_d = ST_EMPTY;
                end else begin
                  fill_we    = 1'b1;
                  fill_new   = cur_fill - FILL_W'(1);
                  ram_re     = 1'b1;
                  ram_raddr  = cur_base + ADDR_W'(fill_new);
                  run_fill_d = fill_new;
                  state_d    = S_POP;
                end
              end
              OP_DUMP: begin
                if (cur_fill == '0) begin
                  load_out     = 1'b1;
                  out_status_d = ST_EMPTY;
                end else begin
                  ram_re     = 1'b1;
                  ram_raddr  = cur_base;
                  run_base_d = cur_base;
                  run_fill_d = cur_fill;
                  run_idx_d  = '0;
                  state_d    = S_DUMP;
                end
              end
              default: begin
                load_out = 1'b1;
              end
            endcase
          end
        end
      end
      S_POP: begin
        out_data_d = rd_word;
        out_fill_d = run_fill_q;
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_DUMP: begin
        out_data_d = rd_word;
        out_fill_d = run_fill_q;
        out_last_d = run_last;
        if (out_free) begin
          load_out = 1'b1;
          if (run_last) begin
            state_d = S_IDLE;
          end else begin
            // Fetch the next entry while this one goes out
            ram_re    = 1'b1;
            ram_raddr = run_base_q + ADDR_W'(run_idx_q) + ADDR_W'(1);
            run_idx_d = run_idx_q + FILL_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold a finished word until taken; drop it on take
  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        fill_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (fill_we) begin
        fill_q[sel_idx] <= fill_new;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    run_base_q <= run_base_d;
    run_fill_q <= run_fill_d;
    run_idx_q  <= run_idx_d;
    if (load_out) begin
      out_data_q   <= out_data_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
      out_fill_q   <= out_fill_d;
      out_flags_q  <= out_flags_d;
    end
  end

  // Drive outputs
  assign out_valid_o   = out_valid_q;
  assign data_out_o    = out_data_q;
  assign status_o      = out_status_q;
  assign last_of_run_o = out_last_q;
  assign is_full_o     = out_flags_q && (out_fill_q >= FILL_W'(PART));
  assign is_empty_o    = out_flags_q && (out_fill_q == '0);
  assign fill_count_o  = CNT_W'(out_fill_q);

  // Read-out index stays inside the captured fill
  a_dump_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |-> (run_idx_q < run_fill_q))
    else $error("read-out index past fill count");

  // Memory writes happen only while idle
  a_we_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_IDLE))
    else $error("entry write outside idle");

  // A pop result that can leave returns the block to idle
  a_pop_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_POP) && out_free) |=> (state_q == S_IDLE))
    else $error("pop did not complete");

  // Final read-out word carries the last mark and ends the run
  a_dump_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DUMP) && out_free && run_last) |=>
      (out_valid_q && out_last_q && (state_q == S_IDLE)))
    else $error("read-out run end mismatch");

  // A new item never enters while a multi-cycle item is active
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_POP) || (state_q == S_DUMP)) |-> in_stall_o)
    else $error("input taken while busy");

endmodule
